FILE: src/bmh_pkg.sv
package bmh_pkg;

  // Heap geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int STAT_W   = 2;
  // child index math needs room for 2*pos+2
  localparam int CI_W     = IDX_W + 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CI_W-1:0]         cidx_t;
  typedef logic [STAT_W-1:0]       stat_t;
  typedef logic [COUNT_W-1:0]      count_t;

  // Operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Status codes
  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_FULL  = 2'd1;
  localparam stat_t ST_EMPTY = 2'd2;

  // Result of one compare step
  typedef struct packed {
    logic take;        // candidate beats the moving key
    logic pick_right;  // right child chosen over left
    key_t win;         // chosen candidate value
  } cmp_res_t;

endpackage

FILE: src/bmh_cmp.sv
module bmh_cmp (
  input  bmh_pkg::key_t     cur,
  input  bmh_pkg::key_t     left,
  input  bmh_pkg::key_t     right,
  input  logic              right_ok,
  output bmh_pkg::cmp_res_t res
);
  import bmh_pkg::*;

  // Pick the larger child (left on ties), then test it against the moving key
  always_comb begin
    res.pick_right = right_ok && (right > left);
    res.win        = res.pick_right ? right : left;
    res.take       = res.win > cur;
  end

endmodule

FILE: src/binary_max_heap_core.sv
// Binary max-heap of 16 signed 32-bit keys, one operation per input beat.
// Full/empty rejects go straight to the result; an insert appends the key and sifts it up
// toward the root, an extract returns the root and sifts the last entry down from the root.
// One beat at a time: in_ready is high only while idle, so a new beat is taken only after the
// result has moved to the output register, which holds it until out_ready takes it.
// Reset clears the entry count, sequencer and output valid; heap memory is not cleared.
module binary_max_heap_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  bmh_pkg::key_t       key,
  output logic                out_valid,
  input  logic                out_ready,
  output bmh_pkg::key_t       value,
  output bmh_pkg::stat_t      status,
  output bmh_pkg::count_t     count
);
  import bmh_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_RD  = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_EXT    = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t   state;
  cnt_t     cnt;
  idx_t     pos;
  key_t     cur;
  key_t     res_value;
  stat_t    res_status;

  // heap memory, two registered read ports, one write port
  key_t     mem [CAPACITY];
  key_t     rd_a;
  key_t     rd_b;
  idx_t     ra;
  idx_t     rb;
  logic     we;
  idx_t     wa;
  key_t     wd;

  // index helpers
  idx_t     parent;
  cidx_t    lc;
  cidx_t    rc;
  cidx_t    cnt_x;
  logic     in_fire;
  cmp_res_t cmp;
  logic     up_cmp;
  key_t     cmp_cur;
  key_t     cmp_left;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign parent   = (pos - idx_t'(1)) >> 1;
  assign lc       = (cidx_t'(pos) << 1) + cidx_t'(1);
  assign rc       = lc + cidx_t'(1);
  assign cnt_x    = cidx_t'(cnt);

  // sift-up: moving key is the candidate against its parent
  assign up_cmp   = (state == S_UP_CMP);
  assign cmp_cur  = up_cmp ? rd_a : cur;
  assign cmp_left = up_cmp ? cur : rd_a;

  // shared compare: moving key on the left port for sift-up, children for sift-down
  bmh_cmp u_cmp (
    .cur      (cmp_cur),
    .left     (cmp_left),
    .right    (rd_b),
    .right_ok ((state == S_DN_CMP) && (rc < cnt_x)),
    .res      (cmp)
  );

  // memory port control
  always_comb begin
    ra = '0;
    rb = '0;
    we = 1'b0;
    wa = pos;
    wd = cur;
    unique case (state)
      S_IDLE: begin
        ra = '0;
        rb = idx_t'(cnt - cnt_t'(1));
      end
      S_UP_RD: begin
        ra = parent;
        if (pos == '0) begin
          we = 1'b1;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cmp.take) begin
          wd = rd_a;
        end
      end
      S_DN_RD: begin
        ra = idx_t'(lc);
        rb = idx_t'(rc);
        if (lc >= cnt_x) begin
          we = 1'b1;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (cmp.take) begin
          wd = cmp.win;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_value  <= '0;
            res_status <= ST_OK;
            if (op == OP_INSERT) begin
              if (cnt >= cnt_t'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                cur   <= key;
                pos   <= idx_t'(cnt);
                cnt   <= cnt + cnt_t'(1);
                state <= S_UP_RD;
              end
            end else begin
              if (cnt == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                cnt   <= cnt - cnt_t'(1);
                state <= S_EXT;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (cmp.take) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_EXT: begin
          // root and last entry arrive; last entry becomes the hole filler
          res_value <= rd_a;
          cur       <= rd_b;
          pos       <= '0;
          state     <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= (lc >= cnt_x) ? S_DONE : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cmp.take) begin
            pos   <= cmp.pick_right ? idx_t'(rc) : idx_t'(lc);
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hand result to the output register once it is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= res_value;
            status    <= res_status;
            count     <= count_t'(cnt);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
